/* rtl/mksd_pkg.sv */
package mksd_pkg;

    localparam int KEY_SLOTS        = 8;
    localparam int NUM_KEYS_DEFAULT = 8;
    localparam int KEY_IDX_W        = 3;
    localparam int CNT_W            = 4;
    localparam int CFG_IDX_W        = 4;
    localparam int CFG_DATA_W       = 8;

    localparam logic [CNT_W-1:0] CNT_MAX           = '1;
    localparam logic [CNT_W-1:0] CONFIRM_RESET     = CNT_W'(3);
    localparam logic [KEY_SLOTS-1:0] ACTIVE_LOW_RESET = '0;

    localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE_LOW_MASK = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_CONFIRM_SAMPLES = CFG_IDX_W'(1);

    // events confirmed by one tick, one bit per key
    typedef struct packed {
        logic                 valid;
        logic [KEY_SLOTS-1:0] mask;
        logic [KEY_SLOTS-1:0] level;
    } mksd_batch_t;

endpackage

/* rtl/mksd_if.sv */
interface mksd_tick_if;
    import mksd_pkg::*;
    logic                 valid;
    logic                 ready;
    logic [KEY_SLOTS-1:0] pin_levels;

    modport source (output valid, output pin_levels, input ready);
    modport sink   (input valid, input pin_levels, output ready);
endinterface

interface mksd_event_if;
    import mksd_pkg::*;
    logic                 valid;
    logic                 ready;
    logic [KEY_IDX_W-1:0] key_index;
    logic                 pressed;
    logic                 last_event;

    modport source (output valid, output key_index, output pressed, output last_event,
                    input ready);
    modport sink   (input valid, input key_index, input pressed, input last_event,
                    output ready);
endinterface

interface mksd_cfg_if;
    import mksd_pkg::*;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

/* rtl/mksd_core.sv */
module mksd_core #(
    parameter int NUM_KEYS = mksd_pkg::NUM_KEYS_DEFAULT
) (
    input  logic                 clk,
    input  logic                 rst_n,
    mksd_tick_if.sink            tick,
    mksd_cfg_if.sink             cfg,
    output mksd_pkg::mksd_batch_t batch,
    input  logic                 batch_take
);
    import mksd_pkg::*;

    localparam int ACTIVE_KEYS = (NUM_KEYS < KEY_SLOTS) ? NUM_KEYS : KEY_SLOTS;

    logic [KEY_SLOTS-1:0]   active_low_reg;
    logic [CNT_W-1:0]       confirm_reg;

    logic [ACTIVE_KEYS-1:0] conf_reg, conf_next;
    logic [ACTIVE_KEYS-1:0] last_reg, last_next;
    logic [CNT_W-1:0]       cnt_reg  [ACTIVE_KEYS];
    logic [CNT_W-1:0]       cnt_next [ACTIVE_KEYS];

    logic                   batch_valid_reg;
    logic [KEY_SLOTS-1:0]   batch_mask_reg;
    logic [KEY_SLOTS-1:0]   batch_level_reg;

    logic [KEY_SLOTS-1:0]   ev_next;
    logic [KEY_SLOTS-1:0]   lvl_next;
    logic                   accept;

    assign cfg.ready  = 1'b1;
    assign tick.ready = !batch_valid_reg || batch_take;
    assign accept     = tick.valid && tick.ready;

    assign batch.valid = batch_valid_reg;
    assign batch.mask  = batch_mask_reg;
    assign batch.level = batch_level_reg;

    always_comb
    begin
        logic             lvl;
        logic [CNT_W-1:0] inc;
        conf_next = conf_reg;
        last_next = last_reg;
        ev_next   = '0;
        lvl_next  = '0;
        for (int i = 0; i < ACTIVE_KEYS; i++)
        begin
            cnt_next[i] = cnt_reg[i];
            lvl         = tick.pin_levels[i] ^ active_low_reg[i];
            lvl_next[i] = lvl;
            inc         = (cnt_reg[i] == CNT_MAX) ? cnt_reg[i] : cnt_reg[i] + CNT_W'(1);
            if (lvl != last_reg[i])
            begin
                last_next[i] = lvl;
                cnt_next[i]  = CNT_W'(1);
            end
            else if (lvl != conf_reg[i])
            begin
                if (inc >= confirm_reg)
                begin
                    conf_next[i] = lvl;
                    cnt_next[i]  = '0;
                    ev_next[i]   = 1'b1;
                end
                else
                begin
                    cnt_next[i] = inc;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_low_reg <= ACTIVE_LOW_RESET;
            confirm_reg    <= CONFIRM_RESET;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                CFG_ACTIVE_LOW_MASK: active_low_reg <= cfg.data[KEY_SLOTS-1:0];
                CFG_CONFIRM_SAMPLES: confirm_reg    <= cfg.data[CNT_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            conf_reg <= '0;
            last_reg <= '0;
            for (int i = 0; i < ACTIVE_KEYS; i++)
            begin
                cnt_reg[i] <= '0;
            end
        end
        else if (accept)
        begin
            conf_reg <= conf_next;
            last_reg <= last_next;
            for (int i = 0; i < ACTIVE_KEYS; i++)
            begin
                cnt_reg[i] <= cnt_next[i];
            end
        end
    end

    // a tick with no confirmed change leaves nothing for the serialiser
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            batch_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            batch_valid_reg <= |ev_next;
        end
        else if (batch_take)
        begin
            batch_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            batch_mask_reg  <= ev_next;
            batch_level_reg <= lvl_next;
        end
    end

    a_batch_not_empty: assert property (@(posedge clk) disable iff (!rst_n)
        batch_valid_reg |-> (batch_mask_reg != '0))
        else $error("empty event batch held");

    a_batch_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (batch_valid_reg && !batch_take) |=> (batch_valid_reg && $stable(batch_mask_reg)))
        else $error("event batch lost before it was taken");

    a_state_only_on_accept: assert property (@(posedge clk) disable iff (!rst_n)
        !accept |=> ($stable(conf_reg) && $stable(last_reg)))
        else $error("key state moved without a tick");

endmodule

/* rtl/mksd_serializer.sv */
module mksd_serializer (
    input  logic                 clk,
    input  logic                 rst_n,
    input  mksd_pkg::mksd_batch_t batch,
    output logic                 batch_take,
    mksd_event_if.source         events
);
    import mksd_pkg::*;

    logic [KEY_SLOTS-1:0] mask_reg, mask_next;
    logic [KEY_SLOTS-1:0] level_reg;
    logic [KEY_SLOTS-1:0] sel;
    logic [KEY_IDX_W-1:0] sel_idx;
    logic                 last;
    logic                 fire;

    // lowest pending key goes first
    assign sel  = mask_reg & (~mask_reg + KEY_SLOTS'(1));
    assign last = (mask_reg & (mask_reg - KEY_SLOTS'(1))) == '0;
    assign fire = events.valid && events.ready;

    assign batch_take = batch.valid && ((mask_reg == '0) || (fire && last));

    always_comb
    begin
        sel_idx = '0;
        for (int i = KEY_SLOTS - 1; i >= 0; i--)
        begin
            if (mask_reg[i])
            begin
                sel_idx = KEY_IDX_W'(i);
            end
        end
    end

    assign events.valid      = mask_reg != '0;
    assign events.key_index  = sel_idx;
    assign events.pressed    = |(level_reg & sel);
    assign events.last_event = last;

    always_comb
    begin
        mask_next = mask_reg;
        if (fire)
        begin
            mask_next = mask_reg & ~sel;
        end
        if (batch_take)
        begin
            mask_next = batch.mask;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mask_reg <= '0;
        end
        else
        begin
            mask_reg <= mask_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (batch_take)
        begin
            level_reg <= batch.level;
        end
    end

    a_one_key_selected: assert property (@(posedge clk) disable iff (!rst_n)
        events.valid |-> $onehot(sel))
        else $error("event beat does not select exactly one key");

    a_load_only_when_drained: assert property (@(posedge clk) disable iff (!rst_n)
        batch_take |-> ((mask_reg == '0) || (fire && last)))
        else $error("new batch loaded over pending events");

    a_stall_holds_mask: assert property (@(posedge clk) disable iff (!rst_n)
        (events.valid && !events.ready) |=> $stable(mask_reg))
        else $error("pending events changed while stalled");

endmodule

/* rtl/multi_key_sample_debouncer.sv */
// Debounces up to eight keys polled together. Each tick beat carries the raw level of
// every pin; a key's level is inverted where its bit in active_low_mask is set, and a
// new level is confirmed after confirm_samples (at least two) equal samples in a row.
// Each confirmed change leaves as one event beat (key index, pressed or released),
// lowest key first, with last_event set on the final event of that tick. All keys come
// out of reset released; no clearing pass is needed. Key state updates in the cycle a
// tick is accepted, so ticks may come in every cycle unless a batch waits to be taken;
// a tick with k confirmed changes sends k event beats on the single event output (a
// quiet tick sends none), and a one-batch register between the update logic and the
// event output lets the next tick be taken while events of the previous one drain. A
// tick yields at most eight events.
module multi_key_sample_debouncer #(
    parameter int NUM_KEYS = mksd_pkg::NUM_KEYS_DEFAULT
) (
    input  logic         clk,
    input  logic         rst_n,
    mksd_tick_if.sink    tick,
    mksd_cfg_if.sink     cfg,
    mksd_event_if.source events
);
    import mksd_pkg::*;

    mksd_batch_t batch;
    logic        batch_take;

    mksd_core #(
        .NUM_KEYS (NUM_KEYS)
    ) u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .tick       (tick),
        .cfg        (cfg),
        .batch      (batch),
        .batch_take (batch_take)
    );

    mksd_serializer u_serializer (
        .clk        (clk),
        .rst_n      (rst_n),
        .batch      (batch),
        .batch_take (batch_take),
        .events     (events)
    );

endmodule
